/* rtl/core/mms_pkg.sv */
`default_nettype none

package mms_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_W     = $clog2(STACK_DEPTH + 1);

  typedef enum logic [0:0] {
    MMS_PUSH = 1'b0,
    MMS_POP  = 1'b1
  } mms_action_e;

  typedef enum logic [1:0] {
    MMS_OK        = 2'd0,
    MMS_UNDERFLOW = 2'd1,
    MMS_OVERFLOW  = 2'd2
  } mms_status_e;

  typedef struct packed {
    mms_action_e                    action;
    logic signed [VALUE_WIDTH-1:0]  push_value;
  } mms_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  popped_value;
    logic signed [VALUE_WIDTH-1:0]  current_min;
    logic signed [VALUE_WIDTH-1:0]  current_max;
    logic [COUNT_W-1:0]             entry_count;
    mms_status_e                    status;
  } mms_out_t;

  // one stack level: the value and the running extremes at or below it
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  value;
    logic signed [VALUE_WIDTH-1:0]  min;
    logic signed [VALUE_WIDTH-1:0]  max;
  } mms_entry_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } mms_shift_t;

endpackage

`default_nettype wire

/* rtl/core/mms_cell.sv */
`default_nettype none

module mms_cell
  import mms_pkg::*;
(
  input  wire              clk_i,
  input  wire mms_shift_t  shift_i,
  input  wire mms_entry_t  up_i,
  input  wire mms_entry_t  down_i,
  output mms_entry_t       entry_o
);

  mms_entry_t entry_q, entry_d;

  // push moves entries down the row, pop moves them up
  always_comb begin
    entry_d = entry_q;
    if (shift_i.push) begin
      entry_d = up_i;
    end else if (shift_i.pop) begin
      entry_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/core/min_max_stack.sv */
// min_max_stack: signed stack that also reports the running minimum and
// maximum of everything it holds.
// input channel (in_valid_i / in_ready_o / in_data_i): each transaction is a
// push of push_value or a pop of the top entry.
// output channel (out_valid_o / out_ready_i / out_data_o): one transaction per
// input transaction, in order, carrying the popped value, the minimum,
// maximum and entry count after the operation, and a status (ok, underflow
// on a pop of an empty stack, overflow on a push onto a full stack; both
// leave the stack unchanged).
// result: registered, and appears in the cycle after the input is taken.
// throughput: one operation per cycle; the stack is a row of cells that all
// shift together, so the top entry always sits in cell 0 and is read without
// any addressing.
// a new input is taken whenever the output register is empty or is being
// drained in the same cycle; when the receiver stalls, the result holds and
// in_ready_o drops until it is taken.
// reset empties the stack (count zero) and clears the output valid; the
// cells themselves are not cleared, levels at or above the count are never
// read.
`default_nettype none

module min_max_stack
  import mms_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire mms_in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output mms_out_t       out_data_o
);

  // entry count and output register
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  mms_out_t           out_q, out_d;

  // cell row, index 0 is the top of stack
  mms_entry_t cells [STACK_DEPTH];
  mms_entry_t new_top;
  mms_shift_t shift;

  logic accept;
  logic is_pop;
  logic empty;
  logic full;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pop     = (in_data_i.action == MMS_POP);
  assign empty      = (count_q == '0);
  assign full       = (count_q == COUNT_W'(STACK_DEPTH));

  // shift the whole row only for operations that really change the stack
  assign shift.push = accept && !is_pop && !full;
  assign shift.pop  = accept && is_pop && !empty;

  // new top level: extremes fold in the level below, or start fresh when empty
  always_comb begin
    new_top.value = in_data_i.push_value;
    new_top.min   = in_data_i.push_value;
    new_top.max   = in_data_i.push_value;
    if (!empty) begin
      if (cells[0].min < in_data_i.push_value) begin
        new_top.min = cells[0].min;
      end
      if (cells[0].max > in_data_i.push_value) begin
        new_top.max = cells[0].max;
      end
    end
  end

  // the row of cells; the bottom cell pulls in don't-care data on a pop
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    mms_entry_t up, down;
    if (i == 0) begin : g_top
      assign up = new_top;
    end else begin : g_mid_up
      assign up = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down = '0;
    end else begin : g_mid_down
      assign down = cells[i+1];
    end

    mms_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .up_i    (up),
      .down_i  (down),
      .entry_o (cells[i])
    );
  end

  // count update
  always_comb begin
    count_d = count_q;
    if (shift.push) begin
      count_d = count_q + COUNT_W'(1);
    end else if (shift.pop) begin
      count_d = count_q - COUNT_W'(1);
    end
  end

  // result of the accepted operation, as seen after it completes
  always_comb begin
    out_d = out_q;
    if (accept) begin
      out_d.popped_value = '0;
      out_d.current_min  = '0;
      out_d.current_max  = '0;
      out_d.entry_count  = count_d;
      out_d.status       = MMS_OK;
      if (is_pop) begin
        if (empty) begin
          out_d.status = MMS_UNDERFLOW;
        end else begin
          out_d.popped_value = cells[0].value;
          // the level below becomes the top, if there is one
          if (count_q > COUNT_W'(1)) begin
            out_d.current_min = cells[1].min;
            out_d.current_max = cells[1].max;
          end
        end
      end else if (full) begin
        out_d.status      = MMS_OVERFLOW;
        out_d.current_min = cells[0].min;
        out_d.current_max = cells[0].max;
      end else begin
        out_d.current_min = new_top.min;
        out_d.current_max = new_top.max;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // count stays within the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  // a pop of an empty stack reports underflow and keeps it empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_pop && empty |=>
      out_valid_o && out_data_o.status == MMS_UNDERFLOW && count_q == '0)
    else $error("empty pop not reported as underflow");

  // a push onto a full stack leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_pop && full |=>
      out_data_o.status == MMS_OVERFLOW && count_q == COUNT_W'(STACK_DEPTH))
    else $error("full push not dropped");

  // result count always matches the stack count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_data_o.entry_count == count_q)
    else $error("reported count differs from stack count");

  // an empty stack reports zero extremes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_count == '0 |->
      out_data_o.current_min == '0 && out_data_o.current_max == '0)
    else $error("nonzero extremes on empty stack");
`endif

endmodule

`default_nettype wire
